FILE: sv/vcaf_pkg.sv
// shared types and constants for the vertex color ambient fix block
package vcaf_pkg;

   localparam int IndexWidth    = 16;
   localparam int ChanWidth     = 8;
   localparam int EndWidth      = 17;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 17;

   // vertex count limit that trans_end is clipped to before the compare
   localparam logic [EndWidth-1:0] MAX_VERTICES = 17'd65536;

   localparam logic [ChanWidth-1:0] FULL_SCALE     = 8'd255;
   localparam logic [ChanWidth-1:0] EXTERIOR_ALPHA = 8'd255;

   // multiples of 16320 for the late path fraction c*a/16320
   localparam logic [15:0] LATE_STEP_1 = 16'd16320;
   localparam logic [15:0] LATE_STEP_2 = 16'd32640;
   localparam logic [15:0] LATE_STEP_3 = 16'd48960;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FIX_ENABLE     = 3'd0,
      CSR_OUTDOOR_MODE   = 3'd1,
      CSR_GROUP_EXTERIOR = 3'd2,
      CSR_TRANS_END      = 3'd3,
      CSR_AMBIENT_RED    = 3'd4,
      CSR_AMBIENT_GREEN  = 3'd5,
      CSR_AMBIENT_BLUE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                 fix_enable;
      logic                 outdoor_mode;
      logic                 group_exterior;
      logic [EndWidth-1:0]  trans_end;
      logic [ChanWidth-1:0] ambient_red;
      logic [ChanWidth-1:0] ambient_green;
      logic [ChanWidth-1:0] ambient_blue;
   } cfg_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic [ChanWidth-1:0] alpha;
   } pixel_type;

endpackage

FILE: sv/vcaf_if.sv
// channel interfaces for the vertex color ambient fix block
interface vcaf_req_if;
   logic                           valid;
   logic                           ready;
   logic [vcaf_pkg::IndexWidth-1:0] vertex_index;
   logic [vcaf_pkg::ChanWidth-1:0]  red_in;
   logic [vcaf_pkg::ChanWidth-1:0]  green_in;
   logic [vcaf_pkg::ChanWidth-1:0]  blue_in;
   logic [vcaf_pkg::ChanWidth-1:0]  alpha_in;

   modport source (output valid, vertex_index, red_in, green_in, blue_in, alpha_in,
                   input ready);
   modport sink (input valid, vertex_index, red_in, green_in, blue_in, alpha_in,
                 output ready);
endinterface

interface vcaf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vcaf_pkg::ChanWidth-1:0] red_out;
   logic [vcaf_pkg::ChanWidth-1:0] green_out;
   logic [vcaf_pkg::ChanWidth-1:0] blue_out;
   logic [vcaf_pkg::ChanWidth-1:0] alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface vcaf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [vcaf_pkg::CsrIndexWidth-1:0] index;
   logic [vcaf_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/vcaf_csr.sv
// configuration register file for the vertex color ambient fix block
module vcaf_csr (
   input  logic              clock,
   input  logic              reset,
   vcaf_csr_if.sink          csr_if,
   output vcaf_pkg::cfg_type cfg
);

   vcaf_pkg::cfg_type cfg_ff;
   vcaf_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (vcaf_pkg::csr_index_type'(csr_if.index))
            vcaf_pkg::CSR_FIX_ENABLE:     cfg_in.fix_enable     = csr_if.data[0];
            vcaf_pkg::CSR_OUTDOOR_MODE:   cfg_in.outdoor_mode   = csr_if.data[0];
            vcaf_pkg::CSR_GROUP_EXTERIOR: cfg_in.group_exterior = csr_if.data[0];
            vcaf_pkg::CSR_TRANS_END:      cfg_in.trans_end      = csr_if.data;
            vcaf_pkg::CSR_AMBIENT_RED:    cfg_in.ambient_red    = csr_if.data[7:0];
            vcaf_pkg::CSR_AMBIENT_GREEN:  cfg_in.ambient_green  = csr_if.data[7:0];
            vcaf_pkg::CSR_AMBIENT_BLUE:   cfg_in.ambient_blue   = csr_if.data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/vcaf_channel.sv
// per-channel ambient correction datapath, one shared 8x8 multiplier
module vcaf_channel (
   input  logic [vcaf_pkg::ChanWidth-1:0] chan,
   input  logic [vcaf_pkg::ChanWidth-1:0] ambient,
   input  logic [vcaf_pkg::ChanWidth-1:0] alpha,
   input  logic                           late,
   output logic [vcaf_pkg::ChanWidth-1:0] result
);

   logic signed [9:0] diff;
   logic              diff_pos;
   logic [7:0]        diff_mag;
   logic [7:0]        inv_alpha;
   logic [7:0]        mul_a;
   logic [7:0]        mul_b;
   logic [15:0]       product;
   logic [16:0]       div_sum;
   logic [7:0]        early_q;
   logic [1:0]        late_q;
   logic signed [9:0] late_sum;
   logic [7:0]        early_res;
   logic [7:0]        late_res;

   always_comb begin
      diff      = $signed({2'b00, chan}) - $signed({2'b00, ambient});
      diff_pos  = (diff > 10'sd0);
      diff_mag  = diff[7:0];
      inv_alpha = vcaf_pkg::FULL_SCALE - alpha;

      // early path needs (c-amb)*(255-a), late path needs c*a
      mul_a   = late ? chan  : diff_mag;
      mul_b   = late ? alpha : inv_alpha;
      product = {8'b0, mul_a} * {8'b0, mul_b};

      // exact floor(x/255) for x below 65280
      div_sum = {1'b0, product} + {9'b0, product[15:8]} + 17'd1;
      early_q = div_sum[15:8];
      early_res = diff_pos ? early_q : 8'd0;

      // c*a stays below 4*16320, so the fraction adds 0..3
      if (product >= vcaf_pkg::LATE_STEP_3) begin
         late_q = 2'd3;
      end else if (product >= vcaf_pkg::LATE_STEP_2) begin
         late_q = 2'd2;
      end else if (product >= vcaf_pkg::LATE_STEP_1) begin
         late_q = 2'd1;
      end else begin
         late_q = 2'd0;
      end
      late_sum = diff + $signed({8'b0, late_q});
      if (late_sum < 10'sd0) begin
         late_res = 8'd0;
      end else if (late_sum > 10'sd255) begin
         late_res = vcaf_pkg::FULL_SCALE;
      end else begin
         late_res = late_sum[7:0];
      end

      result = late ? late_res : early_res;
   end

endmodule

FILE: sv/vertex_color_ambient_fix.sv
// top level of the vertex color ambient fix block
//
// usage: vertex colors arrive on req_if (vertex_index plus RGBA), one
// corrected RGBA color leaves on rsp_if for every request, in order.
// csr_if writes the seven configuration registers by index; it is always
// ready and should only be written while no request is in flight.
// an accepted request passes the input register, then the result register,
// before it appears on rsp_if. throughput: one request per cycle while the
// receiver keeps rsp_if.ready high, set by the single pass through the
// per-channel multiplier between the two stages.
// the two stages form an elastic pipeline: when the receiver stalls the
// result register holds its value and req_if.ready drops only once the
// input register is also occupied; nothing is dropped or duplicated.
// reset: synchronous, active high; clears all configuration registers to
// zero and empties both pipeline stages.
module vertex_color_ambient_fix (
   input  logic        clock,
   input  logic        reset,
   vcaf_req_if.sink    req_if,
   vcaf_rsp_if.source  rsp_if,
   vcaf_csr_if.sink    csr_if
);

   vcaf_pkg::cfg_type   cfg;

   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   logic [vcaf_pkg::IndexWidth-1:0]   s1_index_ff;
   vcaf_pkg::pixel_type               s1_pixel_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   vcaf_pkg::pixel_type               out_pixel_ff;
   vcaf_pkg::pixel_type               out_pixel_in;

   logic                              advance;
   logic                              req_accept;
   logic [vcaf_pkg::EndWidth-1:0]     end_clip;
   logic                              late;
   logic [vcaf_pkg::ChanWidth-1:0]    red_fix;
   logic [vcaf_pkg::ChanWidth-1:0]    green_fix;
   logic [vcaf_pkg::ChanWidth-1:0]    blue_fix;

   vcaf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_index_ff       <= req_if.vertex_index;
         s1_pixel_ff.red   <= req_if.red_in;
         s1_pixel_ff.green <= req_if.green_in;
         s1_pixel_ff.blue  <= req_if.blue_in;
         s1_pixel_ff.alpha <= req_if.alpha_in;
      end
      if (advance && s1_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   // trans_end past the vertex limit counts every vertex as early
   assign end_clip = (cfg.trans_end > vcaf_pkg::MAX_VERTICES) ? vcaf_pkg::MAX_VERTICES
                                                             : cfg.trans_end;
   assign late     = ({1'b0, s1_index_ff} >= end_clip);

   vcaf_channel u_red (
      .chan    (s1_pixel_ff.red),
      .ambient (cfg.ambient_red),
      .alpha   (s1_pixel_ff.alpha),
      .late    (late),
      .result  (red_fix)
   );

   vcaf_channel u_green (
      .chan    (s1_pixel_ff.green),
      .ambient (cfg.ambient_green),
      .alpha   (s1_pixel_ff.alpha),
      .late    (late),
      .result  (green_fix)
   );

   vcaf_channel u_blue (
      .chan    (s1_pixel_ff.blue),
      .ambient (cfg.ambient_blue),
      .alpha   (s1_pixel_ff.alpha),
      .late    (late),
      .result  (blue_fix)
   );

   always_comb begin
      out_pixel_in = s1_pixel_ff;
      if (cfg.fix_enable) begin
         if (cfg.outdoor_mode) begin
            if (late) begin
               out_pixel_in.alpha = cfg.group_exterior ? vcaf_pkg::EXTERIOR_ALPHA : 8'd0;
            end
         end else begin
            out_pixel_in.red   = red_fix;
            out_pixel_in.green = green_fix;
            out_pixel_in.blue  = blue_fix;
         end
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.red_out   = out_pixel_ff.red;
   assign rsp_if.green_out = out_pixel_ff.green;
   assign rsp_if.blue_out  = out_pixel_ff.blue;
   assign rsp_if.alpha_out = out_pixel_ff.alpha;

   // an empty input stage must always take a request
   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_if.ready)
      else $error("input stage empty but request not accepted");

   // both stages full under a stall must push back
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("request accepted while pipeline is full and stalled");

   // disabled fix passes the color straight through
   a_passthrough : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && !cfg.fix_enable)
      |=> (rsp_if.valid && out_pixel_ff == $past(s1_pixel_ff)))
      else $error("pass-through color altered");

   // outside outdoor mode alpha is never rewritten
   a_alpha_kept : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && !cfg.outdoor_mode)
      |=> (rsp_if.alpha_out == $past(s1_pixel_ff.alpha)))
      else $error("alpha changed outside outdoor mode");

   // outdoor mode only touches alpha
   a_outdoor_rgb : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && cfg.fix_enable && cfg.outdoor_mode)
      |=> (rsp_if.red_out == $past(s1_pixel_ff.red)
           && rsp_if.green_out == $past(s1_pixel_ff.green)
           && rsp_if.blue_out == $past(s1_pixel_ff.blue)))
      else $error("rgb changed in outdoor mode");

endmodule
